### rtl/assert_macros.svh
// Assertion macros used by the top level of the six-bit label decoder.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define SBLD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sbld assertion failed");

// Expression must never be true outside reset.
`define SBLD_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("sbld forbidden condition seen");

// Property that is also checked while reset is applied.
`define SBLD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("sbld reset assertion failed");

`else

`define SBLD_ASSERT(lbl, prop)
`define SBLD_NEVER(lbl, expr)
`define SBLD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### rtl/sbld_pkg.sv
// Package for the six-bit label decoder: item types, code constants, tables.
// No dependencies.
`timescale 1ns / 1ps

package sbld_pkg;

  localparam int CODE_W      = 6;
  localparam int BUF_W       = 13;
  localparam int CNT_W       = 4;
  localparam int CHAR_CNT_W  = 10;

  localparam logic [CHAR_CNT_W-1:0] MAX_LABEL_LEN   = 10'd1023;
  localparam logic [CHAR_CNT_W-1:0] MAX_CHARS_RESET = 10'd511;

  // Shift modes of the back end.
  localparam logic [1:0] MODE_BASE  = 2'd0;
  localparam logic [1:0] MODE_PUNCT = 2'd1;
  localparam logic [1:0] MODE_LOWER = 2'd2;

  // Special codes.
  localparam logic [CODE_W-1:0] CODE_LAST_BASE = 6'h2F;
  localparam logic [CODE_W-1:0] CODE_LOWER     = 6'h1B;
  localparam logic [CODE_W-1:0] CODE_PUNCT     = 6'h1C;
  localparam logic [CODE_W-1:0] CODE_PIPE      = 6'h1D;
  localparam logic [CODE_W-1:0] CODE_UNDER     = 6'h1E;
  localparam logic [CODE_W-1:0] CODE_CARET     = 6'h1F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       label_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       char_valid;
    logic       label_end;
  } out_item_t;

  // One unpacked code; start marks the first code of a new label.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              start;
  } code_entry_t;

  // Handshake between the front end and the code queue.
  typedef struct packed {
    logic        push;
    code_entry_t entry;
  } push_req_t;

  function automatic logic [7:0] base_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    if (code == 6'd0)                      return 8'h20;
    else if (code <= 6'd26)                return c + 8'h40;
    else if (code >= 6'd32 && code <= 6'd41) return c + 8'h10;
    else                                   return 8'h00;
  endfunction

  function automatic logic [7:0] punct_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    if (code == 6'd0)                      return 8'h40;
    else if (code <= 6'd15)                return c + 8'h20;
    else if (code >= 6'd26 && code <= 6'd31) return c + 8'h20;
    else if (code >= 6'd43 && code <= 6'd47) return c + 8'h30;
    else                                   return 8'h00;
  endfunction

  function automatic logic [7:0] lower_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    if (code <= 6'd26) return c + 8'h60;
    else               return 8'h00;
  endfunction

endpackage

### rtl/sbld_front.sv
// Front end of the six-bit label decoder: takes label bytes, keeps the bit
// buffer and pushes one 6-bit code per cycle into the queue while it has room. Uses sbld_pkg.
`timescale 1ns / 1ps

module sbld_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbld_pkg::in_item_t  in_item,
  input  logic                q_full,
  output sbld_pkg::push_req_t push_req
);
  import sbld_pkg::*;

  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             start_r, start_nxt;

  logic [CNT_W-1:0] rem_cnt;
  logic [2:0]       sh;
  logic             push;
  logic             accept;
  logic [BUF_W-1:0] shifted;

  // Bits of a code sit at [cnt-1 : cnt-6]; anything above cnt is stale.
  assign push     = (cnt_r >= CNT_W'(CODE_W)) && !q_full;
  assign sh       = 3'(cnt_r - CNT_W'(CODE_W));
  assign shifted  = buf_r >> sh;
  assign rem_cnt  = push ? (cnt_r - CNT_W'(CODE_W)) : cnt_r;
  assign in_ready = rem_cnt < CNT_W'(CODE_W);
  assign accept   = in_valid && in_ready;

  assign push_req.push        = push;
  assign push_req.entry.code  = shifted[CODE_W-1:0];
  assign push_req.entry.start = start_r;

  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = rem_cnt;
    start_nxt = push ? 1'b0 : start_r;
    if (accept) begin
      start_nxt = in_item.label_start;
      if (in_item.label_start) begin
        buf_nxt = {{(BUF_W-8){1'b0}}, in_item.data_byte};
        cnt_nxt = CNT_W'(8);
      end else begin
        buf_nxt = {buf_r[BUF_W-9:0], in_item.data_byte};
        cnt_nxt = rem_cnt + CNT_W'(8);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      cnt_r   <= '0;
      start_r <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

### rtl/sbld_code_queue.sv
// Two-entry code queue between front and back end of the label decoder.
// Uses sbld_pkg.
`timescale 1ns / 1ps

module sbld_code_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbld_pkg::push_req_t   push_req,
  input  logic                  pop,
  output sbld_pkg::code_entry_t head,
  output logic                  full,
  output logic                  empty
);
  import sbld_pkg::*;

  code_entry_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push_req.push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/sbld_back.sv
// Back end of the label decoder: decodes queued codes through the tables,
// tracks shift mode, character count and label end, and holds the result
// register. Uses sbld_pkg.
`timescale 1ns / 1ps

module sbld_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [9:0]            max_chars,
  input  logic                  q_empty,
  input  sbld_pkg::code_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sbld_pkg::out_item_t   out_item
);
  import sbld_pkg::*;

  logic [1:0]            mode_r, mode_nxt;
  logic [CHAR_CNT_W-1:0] count_r, count_nxt;
  logic                  done_r, done_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic [1:0]            mode_eff;
  logic [CHAR_CNT_W-1:0] count_eff, count_inc, lim0, lim;
  logic                  done_eff;
  logic                  emit, term;
  logic [7:0]            ch;
  logic [1:0]            mode_dec;
  logic                  hit_end;
  logic [7:0]            base_ch;

  assign pop       = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A start flag clears the label state before its code is used.
  assign mode_eff  = head.start ? MODE_BASE : mode_r;
  assign count_eff = head.start ? '0 : count_r;
  assign done_eff  = head.start ? 1'b0 : done_r;

  assign lim0      = (max_chars == '0) ? CHAR_CNT_W'(1) : max_chars;
  assign lim       = (lim0 > MAX_LABEL_LEN) ? MAX_LABEL_LEN : lim0;
  assign count_inc = count_eff + CHAR_CNT_W'(1);
  assign hit_end   = count_inc >= lim;
  assign base_ch   = base_char(head.code);

  always_comb begin
    emit     = 1'b0;
    term     = 1'b0;
    ch       = 8'h00;
    mode_dec = MODE_BASE;
    priority if (mode_eff == MODE_PUNCT) begin
      ch   = punct_char(head.code);
      emit = 1'b1;
    end else if (mode_eff == MODE_LOWER) begin
      ch   = lower_char(head.code);
      emit = 1'b1;
    end else if (head.code > CODE_LAST_BASE) begin
      term = 1'b1;
    end else if (base_ch != 8'h00) begin
      ch   = base_ch;
      emit = 1'b1;
    end else if (head.code == CODE_PUNCT) begin
      mode_dec = MODE_PUNCT;
    end else if (head.code == CODE_LOWER) begin
      mode_dec = MODE_LOWER;
    end else if (head.code == CODE_PIPE) begin
      ch   = 8'h7C;
      emit = 1'b1;
    end else if (head.code == CODE_UNDER) begin
      ch   = 8'h5F;
      emit = 1'b1;
    end else if (head.code == CODE_CARET) begin
      ch   = 8'h5E;
      emit = 1'b1;
    end else begin
      ch   = 8'h40;
      emit = 1'b1;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    if (pop) begin
      mode_nxt  = mode_eff;
      count_nxt = count_eff;
      done_nxt  = done_eff;
      if (!done_eff) begin
        // Codes of a closed label are dropped here.
        mode_nxt = mode_dec;
        if (emit) begin
          count_nxt               = count_inc;
          done_nxt                = hit_end;
          out_valid_nxt           = 1'b1;
          out_item_nxt.character  = ch;
          out_item_nxt.char_valid = 1'b1;
          out_item_nxt.label_end  = hit_end;
        end else if (term) begin
          done_nxt                = 1'b1;
          out_valid_nxt           = 1'b1;
          out_item_nxt.character  = 8'h00;
          out_item_nxt.char_valid = 1'b0;
          out_item_nxt.label_end  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BASE;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/six_bit_label_decoder_core.sv
// Six-bit packed label decoder, top level. Builds on sbld_pkg, sbld_front,
// sbld_code_queue, sbld_back and the macros in assert_macros.svh.
`timescale 1ns / 1ps

// Unpacks text labels stored as 6-bit codes, bytes in MSB first. Each result
// item carries one character, or a terminator (char_valid low, label_end
// high); label_end also rises on the character that reaches max_chars
// (0 acts as 1). Escape codes produce no item, and bytes after a closed label
// produce nothing until one arrives with label_start set.
// Rate: a byte that completes one code is taken every cycle while the queue has
// room; after one that completes two codes the next waits while the front end
// hands the queue one code per cycle. Results pass the bit buffer, code queue
// and result register. max_chars may only be written while the block is idle.
module six_bit_label_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  // Byte input
  input  logic                in_valid,
  output logic                in_ready,
  input  sbld_pkg::in_item_t  in_item,
  // Character output
  output logic                out_valid,
  input  logic                out_ready,
  output sbld_pkg::out_item_t out_item,
  // Configuration: max_chars
  input  logic                cfg_we,
  input  logic [9:0]          cfg_wdata
);
  import sbld_pkg::*;

  `include "assert_macros.svh"

  logic [CHAR_CNT_W-1:0] max_chars_r, max_chars_nxt;

  push_req_t   push_req;
  code_entry_t head;
  logic        q_full, q_empty, pop;

  assign max_chars_nxt = cfg_we ? cfg_wdata : max_chars_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= MAX_CHARS_RESET;
    end else begin
      max_chars_r <= max_chars_nxt;
    end
  end

  // Front end: bit buffer, one code out per cycle while the queue has room.
  sbld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push_req (push_req)
  );

  // Decouples byte intake from result stalls.
  sbld_code_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: table lookup, shift mode, label limit, result register.
  sbld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_chars (max_chars_r),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Front end only pushes when the queue has room.
  `SBLD_NEVER(a_no_push_full, push_req.push && q_full)
  // Back end never pops an empty queue.
  `SBLD_NEVER(a_no_pop_empty, pop && q_empty)
  // An item without a character is always a terminator with a zero character.
  `SBLD_ASSERT(a_term_shape,
    (out_valid && !out_item.char_valid) |-> (out_item.label_end && out_item.character == 8'h00))
  // No result is shown in the cycle after reset.
  `SBLD_ASSERT_ALWAYS(a_reset_idle, $past(!rst_n) |-> !out_valid)

endmodule

### bench/tb.sv
// Self-checking bench for six_bit_label_decoder_core: random packed labels in,
// decoded characters checked against an in-bench label decoder.
// Depends on sbld_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;
  import sbld_pkg::*;

  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CODE_W-1:0] CODE_STOP = 6'h3F;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic [9:0] cfg_wdata;

  always #4 clk = ~clk;

  six_bit_label_decoder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Character maps, filled from strings at time zero.
  byte unsigned base_map  [64];
  byte unsigned punct_map [64];
  byte unsigned lower_map [64];

  // Label decoder state mirrored in the bench.
  logic [BUF_W-1:0]      bit_pool;
  logic [CNT_W-1:0]      held_bits;
  logic [1:0]            esc_mode;
  logic [CHAR_CNT_W-1:0] emitted;
  logic                  closed;
  logic [CHAR_CNT_W-1:0] max_chars_q;

  out_item_t       pending_glyphs[$];
  logic [CODE_W-1:0] code_buf[$];
  out_item_t       want;

  int  bytes_sent  = 0;
  int  mismatches  = 0;
  int  quiet_cycles = 0;
  bit  in_calm  = 1'b0;
  bit  out_calm = 1'b0;

  // Decode one accepted byte; queue every character or terminator it yields.
  task automatic decode_byte(input in_item_t it);
    logic [CODE_W-1:0]     code;
    logic [CNT_W-1:0]      sh;
    logic [BUF_W-1:0]      shifted;
    logic [CHAR_CNT_W-1:0] lim;
    logic [7:0]            ch;
    logic                  emit;
    int                    made;
    out_item_t             r;
    if (it.label_start) begin
      bit_pool  = '0;
      held_bits = '0;
      esc_mode  = MODE_BASE;
      emitted   = '0;
      closed    = 1'b0;
    end
    if (closed) return;
    lim = (max_chars_q == 10'd0) ? 10'd1 : max_chars_q;
    if (lim > MAX_LABEL_LEN) lim = MAX_LABEL_LEN;
    held_bits = {1'b0, held_bits[2:0]};
    if (held_bits > 4'd5) held_bits = 4'd5;
    bit_pool  = {bit_pool[4:0], it.data_byte};
    held_bits = held_bits + 4'd8;
    made = 0;
    while (held_bits >= 4'd6 && !closed && made < 2) begin
      sh        = held_bits - 4'd6;
      shifted   = bit_pool >> sh;
      code      = shifted[CODE_W-1:0];
      bit_pool  = bit_pool & ((13'd1 << sh) - 13'd1);
      held_bits = sh;
      emit = 1'b0;
      ch   = 8'h00;
      if (esc_mode == MODE_PUNCT) begin
        ch = punct_map[code];
        emit = 1'b1;
        esc_mode = MODE_BASE;
      end else if (esc_mode == MODE_LOWER) begin
        ch = lower_map[code];
        emit = 1'b1;
        esc_mode = MODE_BASE;
      end else if (code > CODE_LAST_BASE) begin
        closed = 1'b1;
        r.character  = 8'h00;
        r.char_valid = 1'b0;
        r.label_end  = 1'b1;
        pending_glyphs.push_back(r);
        made++;
      end else if (base_map[code] != 8'h00) begin
        ch = base_map[code];
        emit = 1'b1;
      end else if (code == CODE_PUNCT) begin
        esc_mode = MODE_PUNCT;
      end else if (code == CODE_LOWER) begin
        esc_mode = MODE_LOWER;
      end else begin
        case (code)
          CODE_PIPE:  ch = "|";
          CODE_UNDER: ch = "_";
          CODE_CARET: ch = "^";
          default:    ch = "@";
        endcase
        emit = 1'b1;
      end
      if (emit) begin
        emitted = emitted + 10'd1;
        r.character  = ch;
        r.char_valid = 1'b1;
        r.label_end  = (emitted >= lim);
        if (r.label_end) closed = 1'b1;
        pending_glyphs.push_back(r);
        made++;
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic st);
    int       gap;
    in_item_t it;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    it.data_byte   = b;
    it.label_start = st;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(it);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Pack code_buf MSB first into bytes; the tail byte gets random pad bits.
  task automatic send_codes(input bit fresh);
    int unsigned acc;
    int          nb;
    bit          first;
    acc = 0;
    nb = 0;
    first = 1'b1;
    foreach (code_buf[k]) begin
      acc = (acc << 6) | code_buf[k];
      nb += 6;
      if (nb >= 8) begin
        send_byte(8'(acc >> (nb - 8)), first && fresh);
        first = 1'b0;
        nb -= 8;
        acc &= (1 << nb) - 1;
      end
    end
    if (nb > 0)
      send_byte(8'((acc << (8 - nb)) | $urandom_range(0, (1 << (8 - nb)) - 1)),
                first && fresh);
    code_buf.delete();
  endtask

  // plain: no escapes, so every code is a character.
  task automatic send_label(input int ncodes, input bit plain, input bit closing,
                            input bit fresh);
    logic [CODE_W-1:0] c;
    for (int k = 0; k < ncodes; k++) begin
      if (!plain && $urandom_range(0, 9) == 0) begin
        code_buf.push_back($urandom_range(0, 1) ? CODE_LOWER : CODE_PUNCT);
        code_buf.push_back(6'($urandom_range(0, 63)));
      end else begin
        c = 6'($urandom_range(0, 47));
        if (plain && (c == CODE_LOWER || c == CODE_PUNCT)) c = 6'h00;
        code_buf.push_back(c);
      end
    end
    if (closing) code_buf.push_back(6'($urandom_range(48, 63)));
    send_codes(fresh);
  endtask

  // Mostly well-formed labels, some raw noise bytes and continuations.
  task automatic random_traffic(input int nbytes, input int hi_len);
    int stop_at;
    int pick;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        send_label($urandom_range(0, hi_len), 1'b0, pick < 80, pick < 93);
    end
  endtask

  // Hold the input off until all results are in, then wait out the pipe.
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_max_chars(input logic [9:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    max_chars_q = v;
  endtask

  // All character classes, escapes across byte boundaries, table misses.
  task automatic test_code_tables();
    code_buf = '{6'h00, 6'h01, 6'h1A, CODE_PUNCT, CODE_STOP, 6'h20, 6'h29,
                 CODE_LOWER, 6'h1A, CODE_PIPE, CODE_UNDER, CODE_CARET, 6'h2A,
                 CODE_LAST_BASE, CODE_PUNCT, 6'h00, CODE_PUNCT, CODE_LAST_BASE,
                 CODE_LOWER, 6'h00, CODE_LOWER, CODE_STOP, CODE_PUNCT, 6'h10,
                 CODE_STOP};
    send_codes(1'b1);
    // closed label: ignored
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // terminator as the first code, rest of the byte dropped
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_limit_edges();
    settle(DRAIN_CYCLES);
    set_max_chars(10'd0);   // acts as one
    send_byte(8'h04, 1'b1);
    send_byte(8'h04, 1'b0);
    settle(DRAIN_CYCLES);
    set_max_chars(10'd1);
    random_traffic(40, 6);
  endtask

  task automatic test_default_traffic();
    settle(DRAIN_CYCLES);
    set_max_chars(MAX_CHARS_RESET);
    random_traffic(120, 16);
    settle(0);              // source goes quiet until the output catches up
    random_traffic(40, 16);
  endtask

  task automatic test_short_limits();
    repeat (4) begin
      settle(DRAIN_CYCLES);
      set_max_chars(10'($urandom_range(2, 20)));
      random_traffic(25, 24);
    end
  endtask

  // One label long enough to hit the widest limit.
  task automatic test_full_length();
    settle(DRAIN_CYCLES);
    set_max_chars(10'd1023);
    send_label(1023, 1'b1, 1'b0, 1'b1);
    random_traffic(30, 12);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: char %h valid %b end %b",
                   out_item.character, out_item.char_valid, out_item.label_end);
      end else begin
        want = pending_glyphs.pop_front();
        if (out_item.character !== want.character ||
            out_item.char_valid !== want.char_valid ||
            out_item.label_end !== want.label_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected char %h valid %b end %b, got char %h valid %b end %b",
                     want.character, want.char_valid, want.label_end,
                     out_item.character, out_item.char_valid, out_item.label_end);
        end
      end
    end
  end

  // Output backpressure, one random stall per result.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    string s;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    for (int i = 0; i < 64; i++) begin
      base_map[i]  = 8'h00;
      punct_map[i] = 8'h00;
      lower_map[i] = 8'h00;
    end
    s = " ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    for (int i = 0; i < s.len(); i++) base_map[i] = s[i];
    s = "0123456789";
    for (int i = 0; i < s.len(); i++) base_map[32 + i] = s[i];
    s = "@!\"#$%&'()*+,-./";
    for (int i = 0; i < s.len(); i++) punct_map[i] = s[i];
    s = ":;<=>?";
    for (int i = 0; i < s.len(); i++) punct_map[26 + i] = s[i];
    s = "[\\]^_";
    for (int i = 0; i < s.len(); i++) punct_map[43 + i] = s[i];
    s = "`abcdefghijklmnopqrstuvwxyz";
    for (int i = 0; i < s.len(); i++) lower_map[i] = s[i];

    bit_pool    = '0;
    held_bits   = '0;
    esc_mode    = MODE_BASE;
    emitted     = '0;
    closed      = 1'b0;
    max_chars_q = MAX_CHARS_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_code_tables();
    test_limit_edges();
    test_default_traffic();
    test_short_limits();
    test_full_length();

    settle(DRAIN_CYCLES);
    if (mismatches == 0 && pending_glyphs.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sbld_pkg.sv
rtl/sbld_front.sv
rtl/sbld_code_queue.sv
rtl/sbld_back.sv
rtl/six_bit_label_decoder_core.sv
bench/tb.sv
